// File: rtl/kwm_pkg.sv
// shared types and codes for the k-way sorted list merge core
// no dependencies
package kwm_pkg;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_CLOSE = 2'd1,
        OP_POP   = 2'd2,
        OP_CLEAR = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_LISTS = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic exec_simple;
        logic scan_start;
        logic scan_issue;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic res_free;
        logic no_lists;
        logic last_issue;
        logic pipe_empty;
    } t_sts;

endpackage

// File: rtl/kwm_if.sv
// valid/ready channel interfaces for the merge core
// depends on kwm_pkg
interface kwm_in_if import kwm_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface kwm_out_if import kwm_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] merged_value;
    logic        final_item;

    modport source (output valid, output status, output merged_value, output final_item,
                    input ready);
    modport sink   (input valid, input status, input merged_value, input final_item,
                    output ready);
endinterface

// File: rtl/k_way_sorted_list_merge_core.sv
// top level of the k-way sorted list merge core
// depends on kwm_pkg, kwm_if, kwm_ctrl, kwm_datapath
//
//   channel  dir  payload                              handshake
//   i_in     in   opcode[1:0], value[31:0]             valid/ready
//   o_out    out  status[1:0], merged_value[31:0],     valid/ready
//                 final_item
//
// push, close, clear and a pop with no closed list execute on acceptance; the result is
//   registered twice, in the result and then the output register, and shows on o_out
// a pop over closed lists runs as: accept, one table read per list, a drain of the
//   head/store read pipeline, then one head update
// synchronous active-low reset clears counters, scan and output valid; no clearing pass
// input stalls in a pop scan and while both result stages are full and o_out not ready
module k_way_sorted_list_merge_core import kwm_pkg::*; #(
    parameter int MAX_ITEMS = 1024,
    parameter int MAX_LISTS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kwm_in_if.sink    i_in,
    kwm_out_if.source o_out
);
    t_cmd w_cmd;
    t_sts w_sts;

    kwm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .i_opcode (i_in.opcode),
        .o_ready  (i_in.ready),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd)
    );

    kwm_datapath #(.MAX_ITEMS(MAX_ITEMS), .MAX_LISTS(MAX_LISTS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_opcode       (i_in.opcode),
        .i_value        (i_in.value),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_status       (o_out.status),
        .o_merged_value (o_out.merged_value),
        .o_final_item   (o_out.final_item)
    );
endmodule

// File: rtl/kwm_ram.sv
// generic simple dual port ram with registered read
// no dependencies
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: rtl/kwm_datapath.sv
// merge datapath: value store, list head/end tables, counters, head scan, result stages
// depends on kwm_pkg and kwm_ram
module kwm_datapath import kwm_pkg::*; #(
    parameter int MAX_ITEMS = 1024,
    parameter int MAX_LISTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_merged_value,
    output logic        o_final_item
);
    localparam int AW  = $clog2(MAX_ITEMS);
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int LW  = $clog2(MAX_LISTS);
    localparam int LCW = $clog2(MAX_LISTS + 1);
    localparam logic [CW-1:0]  MaxItemsC = CW'(MAX_ITEMS);
    localparam logic [LCW-1:0] MaxListsC = LCW'(MAX_LISTS);

    logic [CW-1:0]  r_fill, n_fill;
    logic [CW-1:0]  r_open, n_open;
    logic [LCW-1:0] r_closed, n_closed;
    logic [CW-1:0]  r_remain, n_remain;

    logic [LW-1:0]  r_idx;
    logic           r_p1_vld;
    logic [LW-1:0]  r_p1_idx;
    logic           r_p2_vld;
    logic [LW-1:0]  r_p2_idx;
    logic [CW-1:0]  r_p2_head;

    logic           r_found;
    logic [LW-1:0]  r_best_idx;
    logic [CW-1:0]  r_best_head;
    logic [31:0]    r_best_val;

    logic           r_res_vld;
    logic [1:0]     r_res_status;
    logic [31:0]    r_res_value;
    logic           r_res_final;
    logic           r_out_vld;
    logic [1:0]     r_out_status;
    logic [31:0]    r_out_value;
    logic           r_out_final;

    logic           w_store_we;
    logic           w_head_we;
    logic [LW-1:0]  w_head_waddr;
    logic [CW-1:0]  w_head_wdata;
    logic           w_end_we;
    logic [CW-1:0]  w_head_q;
    logic [CW-1:0]  w_end_q;
    logic [31:0]    w_store_q;
    logic           w_p1_live;
    logic           w_res_move;
    logic           w_res_load;
    logic [1:0]     w_res_status;
    logic [31:0]    w_res_value;
    logic           w_res_final;

    kwm_ram #(.WIDTH(32), .DEPTH(MAX_ITEMS)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_store_we),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (i_value),
        .i_rd_addr (w_head_q[AW-1:0]),
        .o_rd_data (w_store_q)
    );

    kwm_ram #(.WIDTH(CW), .DEPTH(MAX_LISTS)) u_head (
        .i_clk     (i_clk),
        .i_wr_en   (w_head_we),
        .i_wr_addr (w_head_waddr),
        .i_wr_data (w_head_wdata),
        .i_rd_addr (r_idx),
        .o_rd_data (w_head_q)
    );

    kwm_ram #(.WIDTH(CW), .DEPTH(MAX_LISTS)) u_end (
        .i_clk     (i_clk),
        .i_wr_en   (w_end_we),
        .i_wr_addr (r_closed[LW-1:0]),
        .i_wr_data (r_fill),
        .i_rd_addr (r_idx),
        .o_rd_data (w_end_q)
    );

    // push, close, clear and pop bookkeeping
    always_comb begin
        n_fill       = r_fill;
        n_open       = r_open;
        n_closed     = r_closed;
        n_remain     = r_remain;
        w_store_we   = 1'b0;
        w_head_we    = 1'b0;
        w_head_waddr = r_closed[LW-1:0];
        w_head_wdata = r_open;
        w_end_we     = 1'b0;
        w_res_load   = 1'b0;
        w_res_status = ST_OK;
        w_res_value  = '0;
        w_res_final  = 1'b0;
        if (i_cmd.exec_simple) begin
            w_res_load = 1'b1;
            case (i_opcode)
                OP_PUSH: begin
                    if (r_fill >= MaxItemsC) begin
                        w_res_status = ST_FULL;
                    end else begin
                        w_store_we = 1'b1;
                        n_fill     = r_fill + CW'(1);
                    end
                end
                OP_CLOSE: begin
                    if (r_closed >= MaxListsC) begin
                        w_res_status = ST_LISTS;
                    end else begin
                        w_head_we = 1'b1;
                        w_end_we  = 1'b1;
                        n_remain  = r_remain + (r_fill - r_open);
                        n_closed  = r_closed + LCW'(1);
                        n_open    = r_fill;
                    end
                end
                OP_POP: begin
                    w_res_status = ST_EMPTY;
                end
                OP_CLEAR: begin
                    n_fill   = '0;
                    n_open   = '0;
                    n_closed = '0;
                    n_remain = '0;
                end
                default: begin
                    w_res_status = ST_OK;
                end
            endcase
        end else if (i_cmd.finish) begin
            w_res_load = 1'b1;
            if (r_found) begin
                w_head_we    = 1'b1;
                w_head_waddr = r_best_idx;
                w_head_wdata = r_best_head + CW'(1);
                n_remain     = (r_remain != '0) ? r_remain - CW'(1) : r_remain;
                w_res_value  = r_best_val;
                w_res_final  = (r_remain <= CW'(1));
            end else begin
                w_res_status = ST_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_open   <= '0;
            r_closed <= '0;
            r_remain <= '0;
        end else begin
            r_fill   <= n_fill;
            r_open   <= n_open;
            r_closed <= n_closed;
            r_remain <= n_remain;
        end
    end

    // head scan pipeline: table read, store read, signed compare
    assign w_p1_live = r_p1_vld && (w_head_q < w_end_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_p1_vld <= i_cmd.scan_issue;
            r_p2_vld <= w_p1_live;
            if (i_cmd.scan_start) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.scan_issue) begin
                r_idx <= r_idx + LW'(1);
            end
            if (r_p2_vld && (!r_found || ($signed(w_store_q) < $signed(r_best_val)))) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_idx  <= r_idx;
        r_p2_idx  <= r_p1_idx;
        r_p2_head <= w_head_q;
        if (r_p2_vld && (!r_found || ($signed(w_store_q) < $signed(r_best_val)))) begin
            r_best_idx  <= r_p2_idx;
            r_best_head <= r_p2_head;
            r_best_val  <= w_store_q;
        end
    end

    // result register then output register
    assign w_res_move = r_res_vld && (!r_out_vld || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_res_load) begin
                r_res_vld <= 1'b1;
            end else if (w_res_move) begin
                r_res_vld <= 1'b0;
            end
            if (w_res_move) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_res_status <= w_res_status;
            r_res_value  <= w_res_value;
            r_res_final  <= w_res_final;
        end
        if (w_res_move) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
            r_out_final  <= r_res_final;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_status       = r_out_status;
    assign o_merged_value = r_out_value;
    assign o_final_item   = r_out_final;

    assign o_sts.res_free   = !r_res_vld || w_res_move;
    assign o_sts.no_lists   = (r_closed == '0);
    assign o_sts.last_issue = (LCW'(r_idx) == (r_closed - LCW'(1)));
    assign o_sts.pipe_empty = !r_p1_vld && !r_p2_vld;

`ifndef SYNTH
    a_fill_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= MaxItemsC) && (r_open <= r_fill))
        else $error("fill or open start out of range");
    a_list_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_closed <= MaxListsC) && (r_remain <= r_fill))
        else $error("list count or remaining count out of range");
    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_found) |-> (r_remain != '0))
        else $error("pop found a head with no remaining items");
`endif
endmodule

// File: rtl/kwm_ctrl.sv
// merge controller: accepts transactions and sequences the head scan for pops
// depends on kwm_pkg
module kwm_ctrl import kwm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_opcode,
    output logic       o_ready,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_ready  = (r_state == S_IDLE) && i_sts.res_free;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if ((i_opcode == OP_POP) && !i_sts.no_lists) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end else begin
                        o_cmd.exec_simple = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    a_pop_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_opcode == OP_POP) && !i_sts.no_lists) |=> (r_state == S_SCAN))
        else $error("pop with closed lists did not start a scan");
    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && i_sts.last_issue) |=> (r_state == S_DRAIN))
        else $error("scan did not stop after the last list");
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("controller state is not one-hot");
`endif
endmodule

// File: bench/kwm_merge_checker.sv
// checker for the k-way sorted list merge core: watches both channels,
// predicts every result from the accepted input transactions and compares them
// depends on kwm_pkg and kwm_if
module kwm_merge_checker import kwm_pkg::*; #(
    parameter int MAX_ITEMS = 1024,
    parameter int MAX_LISTS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    kwm_in_if    i_in,
    kwm_out_if   i_out,
    output int   o_errors,
    output int   o_pending,
    output int   o_accepted,
    output int   o_results,
    output int   o_pops,
    output int   o_empty_pops,
    output int   o_full_drops,
    output int   o_refused_closes
);

    typedef struct packed {
        t_status     status;
        logic [31:0] merged_value;
        logic        final_item;
    } t_merge_result;

    logic [31:0]   value_mem [MAX_ITEMS];
    int unsigned   head_idx [MAX_LISTS];
    int unsigned   end_idx [MAX_LISTS];
    int unsigned   fill_cnt;
    int unsigned   open_start;
    int unsigned   lists_closed;
    int unsigned   items_left;
    t_merge_result merge_result_q[$];

    int err_cnt         = 0;
    int pending_cnt     = 0;
    int accepted_cnt    = 0;
    int result_cnt      = 0;
    int pop_cnt         = 0;
    int empty_pop_cnt   = 0;
    int full_drop_cnt   = 0;
    int refused_cls_cnt = 0;

    assign o_errors         = err_cnt;
    assign o_pending        = pending_cnt;
    assign o_accepted       = accepted_cnt;
    assign o_results        = result_cnt;
    assign o_pops           = pop_cnt;
    assign o_empty_pops     = empty_pop_cnt;
    assign o_full_drops     = full_drop_cnt;
    assign o_refused_closes = refused_cls_cnt;

    function automatic t_merge_result merge_step(t_opcode op, logic [31:0] val);
        t_merge_result     res;
        bit                found;
        int unsigned       best;
        logic signed [31:0] best_v;
        logic signed [31:0] head_v;
        res.status       = ST_OK;
        res.merged_value = '0;
        res.final_item   = 1'b0;
        found            = 1'b0;
        best             = 0;
        best_v           = '0;
        case (op)
            OP_PUSH: begin
                if (fill_cnt >= MAX_ITEMS) begin
                    res.status = ST_FULL;
                end else begin
                    value_mem[fill_cnt] = val;
                    fill_cnt++;
                end
            end
            OP_CLOSE: begin
                if (lists_closed >= MAX_LISTS) begin
                    res.status = ST_LISTS;
                end else begin
                    head_idx[lists_closed] = open_start;
                    end_idx[lists_closed]  = fill_cnt;
                    items_left += fill_cnt - open_start;
                    lists_closed++;
                    open_start = fill_cnt;
                end
            end
            OP_POP: begin
                for (int i = 0; i < lists_closed; i++) begin
                    if (head_idx[i] < end_idx[i]) begin
                        head_v = value_mem[head_idx[i]];
                        // strict compare keeps the earliest closed list on ties
                        if (!found || head_v < best_v) begin
                            found  = 1'b1;
                            best   = i;
                            best_v = head_v;
                        end
                    end
                end
                if (!found) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.merged_value = value_mem[head_idx[best]];
                    head_idx[best]++;
                    if (items_left > 0) items_left--;
                    res.final_item = (items_left == 0);
                end
            end
            default: begin
                fill_cnt     = 0;
                open_start   = 0;
                lists_closed = 0;
                items_left   = 0;
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_merge_result pred;
        t_merge_result want;
        if (!i_rst_n) begin
            fill_cnt     = 0;
            open_start   = 0;
            lists_closed = 0;
            items_left   = 0;
            merge_result_q.delete();
            pending_cnt  = 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                pred = merge_step(t_opcode'(i_in.opcode), i_in.value);
                merge_result_q = {merge_result_q, pred};
                accepted_cnt++;
                case (pred.status)
                    ST_OK:    if (t_opcode'(i_in.opcode) == OP_POP) pop_cnt++;
                    ST_EMPTY: empty_pop_cnt++;
                    ST_FULL:  full_drop_cnt++;
                    default:  refused_cls_cnt++;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                result_cnt++;
                if (merge_result_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result transaction: expected none, actual %0d/%h/%0d",
                             $time, i_out.status, i_out.merged_value, i_out.final_item);
                end else begin
                    want = merge_result_q[0];
                    merge_result_q.delete(0);
                    if (want.status !== i_out.status) begin
                        err_cnt++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, i_out.status);
                    end
                    if (want.merged_value !== i_out.merged_value) begin
                        err_cnt++;
                        $display("%0t: merged_value mismatch: expected %h, actual %h",
                                 $time, want.merged_value, i_out.merged_value);
                    end
                    if (want.final_item !== i_out.final_item) begin
                        err_cnt++;
                        $display("%0t: final_item mismatch: expected %0d, actual %0d",
                                 $time, want.final_item, i_out.final_item);
                    end
                end
            end
            pending_cnt = merge_result_q.size();
        end
    end

endmodule

// File: bench/tb.sv
// testbench top for the k-way sorted list merge core: drives directed and random
// push/close/pop/clear transactions with random idling and gives the verdict
// depends on kwm_pkg, kwm_if, kwm_merge_checker and the core
module tb;
    import kwm_pkg::*;

    localparam int MAX_ITEMS = 1024;
    localparam int MAX_LISTS = 16;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bit quiet       = 1'b0;
    bit sender_gaps = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;
    int sent_cnt    = 0;

    int errors, pending, accepted, results, pops, empty_pops, full_drops, refused_closes;

    kwm_in_if  in_ch ();
    kwm_out_if out_ch ();

    k_way_sorted_list_merge_core #(
        .MAX_ITEMS(MAX_ITEMS),
        .MAX_LISTS(MAX_LISTS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    kwm_merge_checker #(
        .MAX_ITEMS(MAX_ITEMS),
        .MAX_LISTS(MAX_LISTS)
    ) merge_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (in_ch),
        .i_out           (out_ch),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_accepted      (accepted),
        .o_results       (results),
        .o_pops          (pops),
        .o_empty_pops    (empty_pops),
        .o_full_drops    (full_drops),
        .o_refused_closes(refused_closes)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic send_item(input t_opcode op, input logic [31:0] val);
        if (sender_gaps && !quiet && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= op;
        in_ch.value  <= val;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_cnt++;
    endtask

    task automatic push_sorted_list(input int len, input bit narrow);
        int vals[$];
        repeat (len) begin
            if (narrow) vals = {vals, int'($urandom_range(0, 7)) - 4};
            else vals = {vals, int'($urandom())};
        end
        vals.sort();
        foreach (vals[k]) send_item(OP_PUSH, vals[k]);
    endtask

    task automatic run_merge_round(input int list_cnt, input int max_len);
        int total;
        int len;
        bit narrow;
        total  = 0;
        narrow = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) != 0) send_item(OP_CLEAR, $urandom());
        for (int l = 0; l < list_cnt; l++) begin
            len = $urandom_range(0, max_len);
            push_sorted_list(len, narrow);
            send_item(OP_CLOSE, $urandom());
            total += len;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_item(OP_POP, $urandom());
        end
        // leave part of an open list behind now and then
        if ($urandom_range(0, 2) == 0) push_sorted_list($urandom_range(1, 4), narrow);
        repeat (total + $urandom_range(0, 3)) send_item(OP_POP, $urandom());
    endtask

    // result side: random ready bursts, one long hold-off, none at the end
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (quiet) begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else if (hold_req && !hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_done = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    initial begin
        int start_cnt;
        int guard;
        in_ch.valid  <= 1'b0;
        in_ch.opcode <= OP_PUSH;
        in_ch.value  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, empty close, open list on pop, equal heads, empty pop
        sender_gaps = 1'b1;
        send_item(OP_POP, 32'hA5A5_5A5A);
        send_item(OP_CLOSE, 32'hFFFF_FFFF);
        send_item(OP_PUSH, 32'h8000_0000);
        send_item(OP_PUSH, 32'hFFFF_FFFF);
        send_item(OP_PUSH, 32'h0000_0000);
        send_item(OP_PUSH, 32'h7FFF_FFFF);
        send_item(OP_CLOSE, 32'h5A5A_A5A5);
        send_item(OP_PUSH, 32'h0000_0005);
        send_item(OP_POP, 32'hFFFF_FFFF);
        send_item(OP_CLOSE, 32'h0000_0000);
        send_item(OP_PUSH, 32'hFFFF_FFFF);
        send_item(OP_CLOSE, 32'h7FFF_FFFF);
        repeat (6) send_item(OP_POP, $urandom());
        send_item(OP_CLEAR, 32'hFFFF_FFFF);
        send_item(OP_POP, 32'h8000_0000);

        // use every list slot, close past the limit, then drain
        send_item(OP_CLEAR, $urandom());
        repeat (MAX_LISTS) begin
            push_sorted_list($urandom_range(0, 3), 1'b1);
            send_item(OP_CLOSE, $urandom());
        end
        send_item(OP_PUSH, $urandom());
        send_item(OP_CLOSE, $urandom());
        send_item(OP_CLOSE, $urandom());
        repeat (3 * MAX_LISTS) send_item(OP_POP, $urandom());

        // random rounds; the receiver holds off once while these keep coming
        hold_req  = 1'b1;
        start_cnt = sent_cnt;
        while (sent_cnt - start_cnt < 600) begin
            sender_gaps = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 8)) send_item(t_opcode'($urandom_range(0, 3)), $urandom());
            else
                run_merge_round(($urandom_range(0, 7) == 0) ? MAX_LISTS + 2
                                                            : $urandom_range(1, MAX_LISTS), 12);
        end

        quiet = 1'b1;
        run_merge_round(6, 8);
        in_ch.valid <= 1'b0;

        guard = 0;
        while (pending != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);

        $display("covered %0d input transactions and %0d result transactions",
                 accepted, results);
        $display("ok pops %0d, empty pops %0d, store-full pushes %0d, refused closes %0d",
                 pops, empty_pops, full_drops, refused_closes);
        if (errors == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
